/* rtl/frame_bitmap_allocator_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the frame bitmap allocator.
// Each macro expands to one labelled concurrent assertion, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fba_pkg.sv */
// ----------------------------------------------------------------------------
// fba_pkg
// Shared constants and controller/datapath interface types for the frame
// bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

    // Default number of frames held in the bitmap store.
    localparam int MAX_FRAMES_DEF = 4096;

    // Bits per bitmap word.
    localparam int WORD_BITS = 32;

    // Field widths fixed by the interface.
    localparam int FCOUNT_W = 13;
    localparam int FRAME_W  = 12;

    // Reset value of the frame count register.
    localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = 13'd4096;

    // Request codes.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;      // write a zero word during the clearing pass
        logic sel_in_addr; // read the store at the incoming frame's word
        logic load;        // capture an accepted request
        logic chunk_next;  // move the summary scan to the next chunk
        logic latch_addr;  // hold the word found by the summary scan
        logic set_oof;     // record an exhausted allocation
        logic modify;      // read-modify-write of the held word
        logic emit;        // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;    // clearing pass is on its last word
        logic in_search;   // incoming request needs a frame search
        logic in_map;      // incoming request frees a frame in the store
        logic found;       // current summary chunk has a usable word
        logic last_chunk;  // current summary chunk is the last one
        logic out_free;    // output register can take a word this cycle
    } t_status;

    // Index of the lowest zero bit of a word.
    function automatic logic [4:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [4:0] idx;
        idx = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (!w[k]) begin
                idx = 5'(k);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

/* rtl/fba_ram.sv */
// ----------------------------------------------------------------------------
// fba_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/fba_ctrl.sv */
// ----------------------------------------------------------------------------
// fba_ctrl
// Controller state machine: clearing pass, request dispatch, summary scan,
// read-modify-write and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire fba_pkg::t_status i_status,
    output fba_pkg::t_cmd         o_cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_MODIFY = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.sel_in_addr = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.in_search) begin
                        n_state = ST_SEARCH;
                    end else if (i_status.in_map) begin
                        n_state = ST_MODIFY;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SEARCH: begin
                if (i_status.found) begin
                    o_cmd.latch_addr = 1'b1;
                    n_state = ST_MODIFY;
                end else if (i_status.last_chunk) begin
                    o_cmd.set_oof = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.chunk_next = 1'b1;
                end
            end
            ST_MODIFY: begin
                o_cmd.modify = 1'b1;
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // A new word is taken only when the controller is idle.
    assign o_in_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

/* rtl/fba_dp.sv */
// ----------------------------------------------------------------------------
// fba_dp
// Datapath: bitmap store, per-word full summary, summary scan, word update,
// frame count register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_dp #(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fba_pkg::t_cmd                 i_cmd,
    output fba_pkg::t_status                   o_status,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [fba_pkg::FCOUNT_W-1:0]  i_cfg_wr_data,
    input  wire logic                          i_action,
    input  wire logic [fba_pkg::FRAME_W-1:0]   i_current_frame,
    input  wire logic                          i_is_kernel,
    input  wire logic                          i_is_writable,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic      [fba_pkg::FRAME_W-1:0]   o_entry_frame,
    output logic                               o_present_bit,
    output logic                               o_write_bit,
    output logic                               o_user_bit,
    output logic                               o_entry_updated,
    output logic                               o_out_of_frames
);

    localparam int WB         = fba_pkg::WORD_BITS;
    localparam int MAP_WORDS  = MAX_FRAMES / WB;
    localparam int ADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int NUM_CHUNKS = (MAP_WORDS + WB - 1) / WB;
    localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int PAD_BITS   = NUM_CHUNKS * WB;
    localparam int WIDX_W     = CHUNK_W + 5;
    localparam int CW         = (WIDX_W > 8) ? WIDX_W : 8;
    localparam int FW         = fba_pkg::FRAME_W;

    // Configuration.
    logic [fba_pkg::FCOUNT_W-1:0] r_frame_count;

    // Clearing pass.
    logic [ADDR_W-1:0] r_clr_cnt;

    // Per-word full summary, padded to whole chunks with full words.
    logic [MAP_WORDS-1:0] r_full;
    logic [PAD_BITS-1:0]  w_full_pad;

    // Held request.
    logic              r_action;
    logic              r_kernel;
    logic              r_writable;
    logic [4:0]        r_bit;
    logic [ADDR_W-1:0] r_addr;
    logic [CHUNK_W-1:0] r_chunk;

    // Pending result.
    logic [FW-1:0] r_res_frame;
    logic          r_res_present;
    logic          r_res_write;
    logic          r_res_user;
    logic          r_res_updated;
    logic          r_res_oof;

    // Output register.
    logic          r_out_valid;
    logic [FW-1:0] r_out_frame;
    logic          r_out_present;
    logic          r_out_write;
    logic          r_out_user;
    logic          r_out_updated;
    logic          r_out_oof;

    // Store ports.
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [WB-1:0]     w_wr_data;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [WB-1:0]     w_rd_data;

    // Scan and update signals.
    logic [WB-1:0]      w_chunk_full;
    logic [WB-1:0]      w_avail;
    logic [4:0]         w_cand_j;
    logic [WIDX_W-1:0]  w_cand_idx;
    logic [ADDR_W-1:0]  w_cand_addr;
    logic [ADDR_W-1:0]  w_in_addr;
    logic               w_in_range;
    logic [4:0]         w_zero_k;
    logic [WB-1:0]      w_alloc_word;
    logic [WB-1:0]      w_free_word;
    logic [ADDR_W+4:0]  w_alloc_frame;

    // Pad the summary so that words beyond the store read as full.
    genvar g;
    generate
        for (g = 0; g < PAD_BITS; g++) begin : g_pad
            if (g < MAP_WORDS) begin : g_real
                assign w_full_pad[g] = r_full[g];
            end else begin : g_fill
                assign w_full_pad[g] = 1'b1;
            end
        end
    endgenerate

    // Summary scan: lowest word of the chunk that is not full and is searched.
    assign w_chunk_full = w_full_pad[{r_chunk, 5'd0} +: WB];
    always_comb begin
        for (int j = 0; j < WB; j++) begin
            w_avail[j] = !w_chunk_full[j] &&
                         (CW'({r_chunk, 5'(j)}) < CW'(r_frame_count[12:5]));
        end
    end
    assign w_cand_j    = fba_pkg::first_zero(~w_avail);
    assign w_cand_idx  = {r_chunk, w_cand_j};
    assign w_cand_addr = ADDR_W'(w_cand_idx);

    // Word holding the incoming frame, and whether it lies in the store.
    assign w_in_addr  = ADDR_W'(i_current_frame[11:5]);
    assign w_in_range = ({25'd0, i_current_frame[11:5]} < 32'(MAP_WORDS));

    // Word update for both request kinds.
    assign w_zero_k      = fba_pkg::first_zero(w_rd_data);
    assign w_alloc_word  = w_rd_data | (WB'(1) << w_zero_k);
    assign w_free_word   = w_rd_data & ~(WB'(1) << r_bit);
    assign w_alloc_frame = {r_addr, w_zero_k};

    // Store port selection.
    always_comb begin
        w_wr_en   = i_cmd.clr_wr || i_cmd.modify;
        w_wr_addr = i_cmd.clr_wr ? r_clr_cnt : r_addr;
        if (i_cmd.clr_wr) begin
            w_wr_data = '0;
        end else if (r_action == fba_pkg::ACT_ALLOC) begin
            w_wr_data = w_alloc_word;
        end else begin
            w_wr_data = w_free_word;
        end
        w_rd_addr = i_cmd.sel_in_addr ? w_in_addr : w_cand_addr;
    end

    fba_ram #(
        .WIDTH (WB),
        .DEPTH (MAP_WORDS),
        .AW    (ADDR_W)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Status to the controller.
    always_comb begin
        o_status.clr_last   = (r_clr_cnt == ADDR_W'(MAP_WORDS - 1));
        o_status.in_search  = (i_action == fba_pkg::ACT_ALLOC) && (i_current_frame == '0);
        o_status.in_map     = (i_action == fba_pkg::ACT_FREE) && (i_current_frame != '0)
                              && w_in_range;
        o_status.found      = |w_avail;
        o_status.last_chunk = (r_chunk == CHUNK_W'(NUM_CHUNKS - 1));
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    // Control registers: configuration, clearing counter, scan chunk, summary.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= fba_pkg::FCOUNT_RESET;
            r_clr_cnt     <= '0;
            r_chunk       <= '0;
            r_full        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_frame_count <= i_cfg_wr_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
            end
            if (i_cmd.load) begin
                r_chunk <= '0;
            end else if (i_cmd.chunk_next) begin
                r_chunk <= r_chunk + CHUNK_W'(1);
            end
            if (i_cmd.modify) begin
                if (r_action == fba_pkg::ACT_ALLOC) begin
                    r_full[r_addr] <= &w_alloc_word;
                end else begin
                    r_full[r_addr] <= 1'b0;
                end
            end
        end
    end

    // Held request and pending result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action      <= i_action;
            r_kernel      <= i_is_kernel;
            r_writable    <= i_is_writable;
            r_bit         <= i_current_frame[4:0];
            r_addr        <= w_in_addr;
            r_res_present <= 1'b0;
            r_res_write   <= 1'b0;
            r_res_user    <= 1'b0;
            r_res_oof     <= 1'b0;
            if (i_action == fba_pkg::ACT_ALLOC) begin
                r_res_frame   <= i_current_frame;
                r_res_updated <= 1'b0;
            end else begin
                r_res_frame   <= '0;
                r_res_updated <= (i_current_frame != '0);
            end
        end
        if (i_cmd.latch_addr) begin
            r_addr <= w_cand_addr;
        end
        if (i_cmd.set_oof) begin
            r_res_frame   <= '0;
            r_res_updated <= 1'b0;
            r_res_oof     <= 1'b1;
        end
        if (i_cmd.modify) begin
            if (r_action == fba_pkg::ACT_ALLOC) begin
                r_res_frame   <= FW'(w_alloc_frame);
                r_res_present <= 1'b1;
                r_res_write   <= r_writable;
                r_res_user    <= !r_kernel;
                r_res_updated <= 1'b1;
            end else begin
                r_res_frame   <= '0;
                r_res_updated <= 1'b1;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_frame   <= r_res_frame;
            r_out_present <= r_res_present;
            r_out_write   <= r_res_write;
            r_out_user    <= r_res_user;
            r_out_updated <= r_res_updated;
            r_out_oof     <= r_res_oof;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_entry_frame   = r_out_frame;
    assign o_present_bit   = r_out_present;
    assign o_write_bit     = r_out_write;
    assign o_user_bit      = r_out_user;
    assign o_entry_updated = r_out_updated;
    assign o_out_of_frames = r_out_oof;

endmodule

`default_nettype wire

/* rtl/frame_bitmap_allocator_top.sv */
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_top
// First-fit page frame allocator over a used/free bitmap of physical frames.
// ----------------------------------------------------------------------------
// After reset the block clears its bitmap store, one word a cycle, and holds
// o_in_stall high meanwhile; frame_count may be written during that pass or
// whenever no request is in progress. A request word then occupies the block
// until its result goes to the output register. An allocation that searches
// scans the per-word full summary 32 words a cycle, chunk by chunk, until a
// usable word turns up (one chunk holds 32 summary words and covers 1024
// frames), then updates that word by a read-modify-write that uses the
// registered read of the bitmap store; an exhausted search stops after the
// last chunk; a free of a frame in the store goes straight to the
// read-modify-write; any other request goes straight to the result. The
// result word sits in an output register, so the next request is taken
// while an earlier result still waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_bitmap_allocator_top_assert.svh"

module frame_bitmap_allocator_top #(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration.
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [fba_pkg::FCOUNT_W-1:0] i_cfg_wr_data,
    // Request channel.
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_action,
    input  wire logic [fba_pkg::FRAME_W-1:0]  i_current_frame,
    input  wire logic                         i_is_kernel,
    input  wire logic                         i_is_writable,
    // Result channel.
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [fba_pkg::FRAME_W-1:0]  o_entry_frame,
    output logic                              o_present_bit,
    output logic                              o_write_bit,
    output logic                              o_user_bit,
    output logic                              o_entry_updated,
    output logic                              o_out_of_frames
);

    fba_pkg::t_cmd    w_cmd;
    fba_pkg::t_status w_status;

    // Controller.
    fba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    fba_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_action        (i_action),
        .i_current_frame (i_current_frame),
        .i_is_kernel     (i_is_kernel),
        .i_is_writable   (i_is_writable),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_entry_frame   (o_entry_frame),
        .o_present_bit   (o_present_bit),
        .o_write_bit     (o_write_bit),
        .o_user_bit      (o_user_bit),
        .o_entry_updated (o_entry_updated),
        .o_out_of_frames (o_out_of_frames)
    );

    // Checks on the block's own behaviour.
    `FBA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_in_valid && !o_in_stall, o_in_stall,
        "request taken while the previous one is still in progress")
    `FBA_ASSERT_SAME(a_oof_no_update, i_clk, i_rst_n,
        o_out_valid && o_out_of_frames,
        !o_entry_updated && !o_present_bit && (o_entry_frame == '0),
        "exhausted allocation reports an entry change")
    `FBA_ASSERT_SAME(a_present_updates, i_clk, i_rst_n,
        o_out_valid && o_present_bit, o_entry_updated && !o_out_of_frames,
        "present bit without an entry update")

endmodule

`default_nettype wire
